### rtl/lgcm_pkg.sv
// lgcm_pkg: shared types, constants and the x linearization for the light-gun mapper
// no dependencies; used by lgcm_cal, lgcm_map and the top module
package lgcm_pkg;

    // default calibration sample count
    localparam int SAMPLE_COUNT_DEF = 10;

    // field widths
    localparam int GUN_W      = 9;
    localparam int CENTER_W   = 9;
    localparam int OFF_W      = 9;
    localparam int CROSS_X_W  = 11;
    localparam int CROSS_Y_W  = 10;
    localparam int MODE_W     = 2;
    localparam int OP_W       = 2;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 48;

    // register reset values
    localparam logic [CENTER_W-1:0] CENTER_X_RST = 9'd160;
    localparam logic [CENTER_W-1:0] CENTER_Y_RST = 9'd112;

    // linearization bands and the sprite origin shift
    localparam int LIN_LO_START = 20;
    localparam int LIN_LO_END   = 183;
    localparam int LIN_HI_START = 229;
    localparam int LIN_HI_END   = 255;
    localparam int LIN_HI_BASE  = 326;
    localparam int LIN_MAX      = 376;
    localparam int CROSS_SHIFT  = 8;

    // saturation limits
    localparam int OFF_MIN     = -256;
    localparam int OFF_MAX     = 255;
    localparam int CROSS_Y_MIN = -512;
    localparam int CROSS_Y_MAX = 511;

    // event codes carried in s_tuser
    typedef enum logic [OP_W-1:0] {
        OP_POSITION = 2'd0,
        OP_START    = 2'd1,
        OP_MODE     = 2'd2,
        OP_TRIGGER  = 2'd3
    } op_t;

    // drawing modes
    typedef enum logic [MODE_W-1:0] {
        MODE_RAW     = 2'd0,
        MODE_LIN     = 2'd1,
        MODE_LIN_OFS = 2'd2
    } mode_t;

    // configuration register indexes
    typedef enum logic {
        REG_CENTER_X = 1'b0,
        REG_CENTER_Y = 1'b1
    } cfg_reg_t;

    // calibration/mode view handed from the state block to the mapper
    typedef struct packed {
        mode_t                     mode;
        logic                      cal;
        logic signed [OFF_W-1:0]   off_x;
        logic signed [OFF_W-1:0]   off_y;
    } view_t;

    // piecewise x linearization, 0..376
    function automatic logic [GUN_W-1:0] lin_x(input logic signed [GUN_W-1:0] x);
        logic signed [GUN_W-1:0] d_lo;
        logic signed [GUN_W-1:0] d_hi;
        logic [GUN_W-1:0]        res;
        d_lo = x - GUN_W'(LIN_LO_START);
        d_hi = x - GUN_W'(LIN_HI_START);
        if (x >= $signed(GUN_W'(LIN_LO_START)) && x < $signed(GUN_W'(LIN_LO_END))) begin
            res = {d_lo[GUN_W-2:0], 1'b0};
        end else if (x >= $signed(GUN_W'(LIN_HI_START))
                     && x < $signed(GUN_W'(LIN_HI_END))) begin
            res = GUN_W'(LIN_HI_BASE) + {d_hi[GUN_W-2:0], 1'b0};
        end else begin
            res = '0;
        end
        return res;
    endfunction

endpackage

### rtl/lgcm_div.sv
// lgcm_div: signed truncating divide of a calibration sum by the constant sample count
// depends on nothing but its parameters; reciprocal multiply, exact over the sum range
module lgcm_div #(
    parameter int N     = 10,
    parameter int SUM_W = 13
) (
    input  logic signed [SUM_W-1:0] sum,
    output logic signed [SUM_W-1:0] quot
);

    localparam int     SH       = SUM_W + $clog2(N);
    localparam int     M_W      = SH + 1;
    localparam int     P_W      = SUM_W + M_W;
    localparam longint RECIP_L  = ((longint'(1) << SH) + longint'(N) - 1) / longint'(N);
    localparam logic [M_W-1:0] RECIP = M_W'(RECIP_L);

    logic [SUM_W-1:0] mag;
    logic [P_W-1:0]   prod;
    logic [SUM_W-1:0] q_mag;

    // magnitude, scaled reciprocal, restore sign (truncates toward zero)
    always_comb begin
        mag   = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
        prod  = P_W'(mag) * P_W'(RECIP);
        q_mag = prod[SH +: SUM_W];
        quot  = sum[SUM_W-1] ? $signed(SUM_W'(-q_mag)) : $signed(q_mag);
    end

endmodule

### rtl/lgcm_cal.sv
// lgcm_cal: mode register, calibration sample sums and offset computation
// depends on lgcm_pkg and lgcm_div
module lgcm_cal #(
    parameter int SAMPLE_COUNT = lgcm_pkg::SAMPLE_COUNT_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   step,
    input  lgcm_pkg::op_t                          op,
    input  logic signed [lgcm_pkg::GUN_W-1:0]      gun_x,
    input  logic signed [lgcm_pkg::GUN_W-1:0]      gun_y,
    input  logic [lgcm_pkg::CENTER_W-1:0]          center_x,
    input  logic [lgcm_pkg::CENTER_W-1:0]          center_y,
    output lgcm_pkg::view_t                        view
);

    localparam int SUM_W = $clog2(lgcm_pkg::LIN_MAX * SAMPLE_COUNT + 1) + 1;
    localparam int CNT_W = $clog2(SAMPLE_COUNT + 1);
    localparam int D_W   = SUM_W + 2;
    localparam int GW    = lgcm_pkg::GUN_W;
    localparam int OW    = lgcm_pkg::OFF_W;

    lgcm_pkg::mode_t          mode_reg, mode_next;
    logic                     cal_reg, cal_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic signed [SUM_W-1:0]  sum_x_reg, sum_x_next;
    logic signed [SUM_W-1:0]  sum_y_reg, sum_y_next;
    logic signed [OW-1:0]     off_x_reg, off_x_next;
    logic signed [OW-1:0]     off_y_reg, off_y_next;

    logic [GW-1:0]            lx;
    logic signed [SUM_W-1:0]  sum_x_add, sum_y_add;
    logic signed [SUM_W-1:0]  avg_x, avg_y;
    logic [CNT_W-1:0]         cnt_inc;
    logic                     last;
    logic signed [D_W-1:0]    diff_x, diff_y;
    logic signed [OW-1:0]     sat_x, sat_y;

    // running sums including the current sample
    always_comb begin
        lx        = lgcm_pkg::lin_x(gun_x);
        sum_x_add = sum_x_reg + $signed(SUM_W'(lx));
        sum_y_add = sum_y_reg + SUM_W'(gun_y);
        cnt_inc   = cnt_reg + CNT_W'(1);
        last      = (cnt_inc == CNT_W'(SAMPLE_COUNT));
    end

    lgcm_div #(.N(SAMPLE_COUNT), .SUM_W(SUM_W)) u_div_x (.sum(sum_x_add), .quot(avg_x));
    lgcm_div #(.N(SAMPLE_COUNT), .SUM_W(SUM_W)) u_div_y (.sum(sum_y_add), .quot(avg_y));

    // offset = centre minus average, saturated
    always_comb begin
        diff_x = D_W'($signed({1'b0, center_x})) - D_W'(avg_x);
        diff_y = D_W'($signed({1'b0, center_y})) - D_W'(avg_y);
        if (diff_x < D_W'(lgcm_pkg::OFF_MIN)) begin
            sat_x = OW'(lgcm_pkg::OFF_MIN);
        end else if (diff_x > D_W'(lgcm_pkg::OFF_MAX)) begin
            sat_x = OW'(lgcm_pkg::OFF_MAX);
        end else begin
            sat_x = diff_x[OW-1:0];
        end
        if (diff_y < D_W'(lgcm_pkg::OFF_MIN)) begin
            sat_y = OW'(lgcm_pkg::OFF_MIN);
        end else if (diff_y > D_W'(lgcm_pkg::OFF_MAX)) begin
            sat_y = OW'(lgcm_pkg::OFF_MAX);
        end else begin
            sat_y = diff_y[OW-1:0];
        end
    end

    // event decode and next state
    always_comb begin
        mode_next  = mode_reg;
        cal_next   = cal_reg;
        cnt_next   = cnt_reg;
        sum_x_next = sum_x_reg;
        sum_y_next = sum_y_reg;
        off_x_next = off_x_reg;
        off_y_next = off_y_reg;
        unique case (op)
            lgcm_pkg::OP_START: begin
                cnt_next   = '0;
                sum_x_next = '0;
                sum_y_next = '0;
                cal_next   = 1'b1;
            end
            lgcm_pkg::OP_MODE: begin
                unique case (mode_reg)
                    lgcm_pkg::MODE_RAW: mode_next = lgcm_pkg::MODE_LIN;
                    lgcm_pkg::MODE_LIN: mode_next = lgcm_pkg::MODE_LIN_OFS;
                    default:            mode_next = lgcm_pkg::MODE_RAW;
                endcase
            end
            lgcm_pkg::OP_TRIGGER: begin
                if (cal_reg) begin
                    if (last) begin
                        off_x_next = sat_x;
                        off_y_next = sat_y;
                        cnt_next   = '0;
                        sum_x_next = '0;
                        sum_y_next = '0;
                        cal_next   = 1'b0;
                    end else begin
                        cnt_next   = cnt_inc;
                        sum_x_next = sum_x_add;
                        sum_y_next = sum_y_add;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // state after this request, seen by the mapper
    always_comb begin
        view.mode  = mode_next;
        view.cal   = cal_next;
        view.off_x = off_x_next;
        view.off_y = off_y_next;
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= lgcm_pkg::MODE_RAW;
            cal_reg   <= 1'b0;
            cnt_reg   <= '0;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            off_x_reg <= '0;
            off_y_reg <= '0;
        end else if (step) begin
            mode_reg  <= mode_next;
            cal_reg   <= cal_next;
            cnt_reg   <= cnt_next;
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
            off_x_reg <= off_x_next;
            off_y_reg <= off_y_next;
        end
    end

    // samples are only counted while calibrating
    a_cnt_needs_cal: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != '0 |-> cal_reg)
        else $error("sample count nonzero outside calibration");

    // start clears the count and enters calibration
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        step && op == lgcm_pkg::OP_START |=> cal_reg && cnt_reg == '0 && sum_x_reg == '0)
        else $error("start did not restart calibration");

    // the final sample leaves calibration with cleared sums
    a_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        step && op == lgcm_pkg::OP_TRIGGER && cal_reg && last
        |=> !cal_reg && sum_x_reg == '0 && sum_y_reg == '0)
        else $error("calibration did not end after the last sample");

endmodule

### rtl/lgcm_map.sv
// lgcm_map: crosshair position for the current reading under the drawing mode
// depends on lgcm_pkg
module lgcm_map (
    input  logic signed [lgcm_pkg::GUN_W-1:0]      gun_x,
    input  logic signed [lgcm_pkg::GUN_W-1:0]      gun_y,
    input  lgcm_pkg::view_t                        view,
    output logic signed [lgcm_pkg::CROSS_X_W-1:0]  cross_x,
    output logic signed [lgcm_pkg::CROSS_Y_W-1:0]  cross_y
);

    localparam int XW = lgcm_pkg::CROSS_X_W;
    localparam int YW = lgcm_pkg::CROSS_Y_W;
    localparam int WW = YW + 1;

    logic signed [XW-1:0] gx_w, lx_w, shift_x;
    logic signed [WW-1:0] gy_w, shift_y, cy_ofs;

    // operands widened to output range
    always_comb begin
        gx_w    = XW'(gun_x);
        lx_w    = $signed(XW'(lgcm_pkg::lin_x(gun_x)));
        shift_x = XW'(lgcm_pkg::CROSS_SHIFT);
        gy_w    = WW'(gun_y);
        shift_y = WW'(lgcm_pkg::CROSS_SHIFT);
        cy_ofs  = gy_w + WW'(view.off_y) - shift_y;
    end

    // mode select, y saturates when offsets apply
    always_comb begin
        case (view.mode)
            lgcm_pkg::MODE_RAW: begin
                cross_x = gx_w - shift_x;
                cross_y = YW'(gy_w - shift_y);
            end
            lgcm_pkg::MODE_LIN: begin
                cross_x = lx_w - shift_x;
                cross_y = YW'(gy_w - shift_y);
            end
            default: begin
                cross_x = lx_w + XW'(view.off_x) - shift_x;
                if (cy_ofs < WW'(lgcm_pkg::CROSS_Y_MIN)) begin
                    cross_y = YW'(lgcm_pkg::CROSS_Y_MIN);
                end else if (cy_ofs > WW'(lgcm_pkg::CROSS_Y_MAX)) begin
                    cross_y = YW'(lgcm_pkg::CROSS_Y_MAX);
                end else begin
                    cross_y = cy_ofs[YW-1:0];
                end
            end
        endcase
    end

endmodule

### rtl/light_gun_calibrated_mapper_top.sv
// light_gun_calibrated_mapper_top: a request passes through the input register, then the
// result register, before m_tvalid rises; throughput one request per cycle while m_tready
// does not hold the result register, set by the single compute pass between the two registers.
// aresetn is synchronous, active low: clears mode, calibration, sums, offsets
// and both pipeline valids, and returns center_x/center_y to 160/112.
// depends on lgcm_pkg, lgcm_cal, lgcm_map
module light_gun_calibrated_mapper_top #(
    parameter int SAMPLE_COUNT = lgcm_pkg::SAMPLE_COUNT_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // request channel
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [lgcm_pkg::S_TDATA_W-1:0]         s_tdata,   // gun_x[8:0], gun_y[17:9]
    input  logic [lgcm_pkg::OP_W-1:0]              s_tuser,   // operation[1:0]
    // result channel
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // cross_x[10:0], cross_y[20:11], draw_mode[22:21], calibrating[23],
    // offset_x[32:24], offset_y[41:33]
    output logic [lgcm_pkg::M_TDATA_W-1:0]         m_tdata,
    // configuration writes
    input  logic                                   cfg_wr_en,
    input  logic                                   cfg_index,
    input  logic [lgcm_pkg::CENTER_W-1:0]          cfg_wdata
);

    localparam int GW   = lgcm_pkg::GUN_W;
    localparam int PAD  = lgcm_pkg::M_TDATA_W - lgcm_pkg::CROSS_X_W - lgcm_pkg::CROSS_Y_W
                          - lgcm_pkg::MODE_W - 1 - 2 * lgcm_pkg::OFF_W;

    logic [lgcm_pkg::CENTER_W-1:0]          center_x_reg, center_y_reg;
    logic                                   in_valid_reg;
    lgcm_pkg::op_t                          in_op_reg;
    logic signed [GW-1:0]                   in_gx_reg, in_gy_reg;
    logic                                   out_valid_reg;
    logic [lgcm_pkg::M_TDATA_W-1:0]         out_data_reg, out_data_next;

    logic                                   out_load;
    logic                                   step;
    lgcm_pkg::view_t                        view;
    logic signed [lgcm_pkg::CROSS_X_W-1:0]  cross_x;
    logic signed [lgcm_pkg::CROSS_Y_W-1:0]  cross_y;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg <= lgcm_pkg::CENTER_X_RST;
            center_y_reg <= lgcm_pkg::CENTER_Y_RST;
        end else if (cfg_wr_en) begin
            unique case (lgcm_pkg::cfg_reg_t'(cfg_index))
                lgcm_pkg::REG_CENTER_X: center_x_reg <= cfg_wdata;
                lgcm_pkg::REG_CENTER_Y: center_y_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // pipeline flow control
    always_comb begin
        out_load = !out_valid_reg || m_tready;
        step     = in_valid_reg && out_load;
        s_tready = !in_valid_reg || step;
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg <= lgcm_pkg::op_t'(s_tuser);
            in_gx_reg <= $signed(s_tdata[GW-1:0]);
            in_gy_reg <= $signed(s_tdata[2*GW-1:GW]);
        end
    end

    // calibration and mode state
    lgcm_cal #(.SAMPLE_COUNT(SAMPLE_COUNT)) u_cal (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .op       (in_op_reg),
        .gun_x    (in_gx_reg),
        .gun_y    (in_gy_reg),
        .center_x (center_x_reg),
        .center_y (center_y_reg),
        .view     (view)
    );

    // crosshair mapping
    lgcm_map u_map (
        .gun_x   (in_gx_reg),
        .gun_y   (in_gy_reg),
        .view    (view),
        .cross_x (cross_x),
        .cross_y (cross_y)
    );

    // result packing
    always_comb begin
        out_data_next = {{PAD{1'b0}}, view.off_y, view.off_x, view.cal, view.mode,
                         cross_y, cross_x};
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
